### rtl/imgds_pkg.sv
// ----------------------------------------------------------------------------
// imgds_pkg
// Types and constants shared by the 2x2 box-average image downscaler.
// ----------------------------------------------------------------------------
package imgds_pkg;

   localparam int CHAN_W = 8;               // one color sample
   localparam int PAIR_W = CHAN_W + 1;      // sum of two samples
   localparam int QUAD_W = CHAN_W + 2;      // sum of four samples
   localparam int DIM_W  = 12;              // width / height register
   localparam int PIX_W  = 3 * CHAN_W;      // packed pixel word

   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

   // register indexes on the csr port
   typedef enum logic [0:0] {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

   // red in the lowest bits
   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } pixel_type;

   typedef struct packed {
      logic [PAIR_W-1:0] blue;
      logic [PAIR_W-1:0] green;
      logic [PAIR_W-1:0] red;
   } pair_type;

endpackage

### rtl/image_downscale_2x2_box_average_core.sv
// ----------------------------------------------------------------------------
// image_downscale_2x2_box_average_core
// Halves an RGB raster stream in both directions by averaging 2x2 blocks.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes input pixels in raster order, one word per cycle at most.
//   rsp_* gives one averaged pixel per 2x2 block; rsp_tlast marks the last
//   pixel of an output row, rsp_tuser the last pixel of the frame.
//   csr_* writes image_width (index 0) and image_height (index 1); write
//   only between frames while no result is outstanding. csr_ready is always
//   high.
// Path: a result word goes to rsp_* from the input word that completes its
//   block through the memory read and pair-sum register, then the output
//   register.
// Throughput: one input word per cycle unless rsp_* stalls; the line store has
//   one read and one write port; all words read, even-row odd columns write.
// Reset: positions and the held pixel clear, registers return to 640 x 480.
//   The line store needs no clearing; each entry is written on an even row
//   before it is read on the following odd row.
// Stall: when rsp_tready is low the output register holds; one more block
//   result can wait in the pair-sum stage before req_tready drops.
// ----------------------------------------------------------------------------
module image_downscale_2x2_box_average_core #(
   parameter int MAX_COLS = 2048,
   parameter int MAX_ROWS = 2048
) (
   input  logic                        clock,
   input  logic                        reset,
   // input pixels
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [imgds_pkg::PIX_W-1:0] req_tdata,  // in_red, in_green, in_blue
   // averaged pixels
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [imgds_pkg::PIX_W-1:0] rsp_tdata,  // out_red, out_green, out_blue
   output logic                        rsp_tlast,  // row_end
   output logic [0:0]                  rsp_tuser,  // frame_end
   // register writes
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [0:0]                  csr_index,
   input  logic [imgds_pkg::DIM_W-1:0] csr_data
);
   import imgds_pkg::*;

   localparam int ColW   = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1;
   localparam int RowW   = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1;
   localparam int CDimW  = $clog2(MAX_COLS + 1);
   localparam int RDimW  = $clog2(MAX_ROWS + 1);
   localparam int Depth  = MAX_COLS / 2;
   localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;

   // configuration
   logic [DIM_W-1:0] image_width_ff, image_height_ff;
   logic [CDimW-1:0] width_eff, width_even, col_next;
   logic [RDimW-1:0] height_eff, height_even, row_next;

   // position and held pixel
   logic [ColW-1:0]  col_ff, col_in;
   logic [RowW-1:0]  row_ff, row_in;
   pixel_type        held_ff, pix_in;

   // pair-sum stage
   logic             s1_valid_ff;
   pair_type         s1_pair_ff, pair_sum;
   pair_type         s1_store_ff;
   logic             s1_rend_ff, s1_fend_ff;
   logic             row_end, frame_end;

   // output register
   logic             rsp_valid_ff;
   pixel_type        rsp_data_ff;
   logic             rsp_last_ff, rsp_user_ff;

   logic             accept, out_ready, s1_ready, emit, store_wr;
   logic [AddrW-1:0] store_addr;
   logic [QUAD_W-1:0] quad_red, quad_green, quad_blue;

   pair_type         store_mem [Depth];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WIDTH_RESET;
         image_height_ff <= HEIGHT_RESET;
      end else if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_IMAGE_WIDTH:  image_width_ff  <= csr_data;
            REG_IMAGE_HEIGHT: image_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // zero reads as one, anything above the maximum as the maximum
   always_comb begin
      if (image_width_ff == '0)
         width_eff = CDimW'(1);
      else if (32'(image_width_ff) > MAX_COLS)
         width_eff = CDimW'(MAX_COLS);
      else
         width_eff = CDimW'(image_width_ff);
      if (image_height_ff == '0)
         height_eff = RDimW'(1);
      else if (32'(image_height_ff) > MAX_ROWS)
         height_eff = RDimW'(MAX_ROWS);
      else
         height_eff = RDimW'(image_height_ff);
   end

   assign width_even  = {width_eff[CDimW-1:1], 1'b0};
   assign height_even = {height_eff[RDimW-1:1], 1'b0};

   // handshake through the two stages
   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign s1_ready   = !s1_valid_ff || out_ready;
   assign req_tready = s1_ready;
   assign accept     = req_tvalid && s1_ready;

   assign pix_in     = pixel_type'(req_tdata);
   assign col_next   = CDimW'(col_ff) + CDimW'(1);
   assign row_next   = RDimW'(row_ff) + RDimW'(1);
   assign emit       = col_ff[0] && row_ff[0];
   assign store_wr   = accept && col_ff[0] && !row_ff[0];
   assign store_addr = AddrW'(col_ff >> 1);

   // odd width gives width_even - 1 as the last output column; width one never matches
   assign row_end    = (col_next == width_even);
   assign frame_end  = row_end && (row_next == height_even);

   always_comb begin
      pair_sum.red   = PAIR_W'(held_ff.red)   + PAIR_W'(pix_in.red);
      pair_sum.green = PAIR_W'(held_ff.green) + PAIR_W'(pix_in.green);
      pair_sum.blue  = PAIR_W'(held_ff.blue)  + PAIR_W'(pix_in.blue);
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (col_next >= width_eff) begin
         col_in = '0;
         row_in = (row_next >= height_eff) ? '0 : RowW'(row_next);
      end else begin
         col_in = ColW'(col_next);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         held_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (!col_ff[0]) begin
            held_ff <= pix_in;
         end
      end
   end

   // line store of pair sums from the even row
   always_ff @(posedge clock) begin
      if (store_wr) begin
         store_mem[store_addr] <= pair_sum;
      end
      if (accept) begin
         s1_store_ff <= store_mem[store_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= accept && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pair_ff <= pair_sum;
         s1_rend_ff <= row_end;
         s1_fend_ff <= frame_end;
      end
   end

   assign quad_red   = QUAD_W'(s1_pair_ff.red)   + QUAD_W'(s1_store_ff.red);
   assign quad_green = QUAD_W'(s1_pair_ff.green) + QUAD_W'(s1_store_ff.green);
   assign quad_blue  = QUAD_W'(s1_pair_ff.blue)  + QUAD_W'(s1_store_ff.blue);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   // divide by four: drop the two low bits
   always_ff @(posedge clock) begin
      if (out_ready && s1_valid_ff) begin
         rsp_data_ff.red   <= quad_red[QUAD_W-1:2];
         rsp_data_ff.green <= quad_green[QUAD_W-1:2];
         rsp_data_ff.blue  <= quad_blue[QUAD_W-1:2];
         rsp_last_ff       <= s1_rend_ff;
         rsp_user_ff       <= s1_fend_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   // frame end only on the last pixel of a row
   a_frame_end_row_end : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_last_ff || !rsp_user_ff))
      else $error("frame end without row end");

   // a completed block reaches the pair-sum stage
   a_block_to_s1 : assert property (@(posedge clock) disable iff (reset)
      (accept && emit) |=> s1_valid_ff)
      else $error("block result lost at pair-sum stage");

   // both stages full and stalled means no intake
   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input taken while pipeline is full");

   // positions stay inside the store range
   a_col_range : assert property (@(posedge clock) disable iff (reset)
      (32'(col_ff) < MAX_COLS) && (32'(row_ff) < MAX_ROWS))
      else $error("position beyond maximum image size");

endmodule
